@@ hw/rtl/ansi_escape_parser_with_sgr_top_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ANSI_ESCAPE_PARSER_WITH_SGR_TOP_MACROS_SVH
`define ANSI_ESCAPE_PARSER_WITH_SGR_TOP_MACROS_SVH
`define AEP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define AEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ hw/rtl/aep_pkg.sv @@
`default_nettype none
package aep_pkg;
	localparam int MaxParams = 16;
	localparam int MaxSeqLen = 64;
	localparam int SlotW = $clog2(MaxParams + 1);
	localparam int IdxW = $clog2(MaxParams);
	localparam int LenW = $clog2(MaxSeqLen + 2);

	localparam logic [2:0] EV_PRINT = 3'd0;
	localparam logic [2:0] EV_CONTROL = 3'd1;
	localparam logic [2:0] EV_CSI = 3'd2;
	localparam logic [2:0] EV_RESET = 3'd3;
	localparam logic [2:0] EV_SAVE = 3'd4;
	localparam logic [2:0] EV_RESTORE = 3'd5;

	localparam logic [19:0] BoldBit = 20'h40000;
	localparam logic [19:0] InvBit = 20'h80000;
	localparam logic [8:0] DefColor = 9'd256;

	typedef enum logic [1:0] {
		DP_NONE,
		DP_BYTE,
		DP_START,
		DP_CLOSE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   prefix_ok;
		logic   sgr_start;
		logic   sgr_step;
		logic   load_default;
		logic   emit;
		logic [2:0] kind;
	} dp_cmd_t;

	typedef struct packed {
		logic overlong;
		logic sgr_done;
		logic out_busy;
	} dp_stat_t;

	function automatic logic [2:0] cube_level(input logic [15:0] v);
		logic [7:0] s;
		begin
			s = (v > 16'd255) ? 8'd255 : v[7:0];
			if (s < 8'd48) cube_level = 3'd0;
			else if (s < 8'd115) cube_level = 3'd1;
			else if (s < 8'd155) cube_level = 3'd2;
			else if (s < 8'd195) cube_level = 3'd3;
			else if (s < 8'd235) cube_level = 3'd4;
			else cube_level = 3'd5;
		end
	endfunction
endpackage
`default_nettype wire

@@ hw/rtl/aep_ctrl.sv @@
`default_nettype none
module aep_ctrl
	import aep_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] byte_value,
	input  dp_stat_t        stat,
	output logic            in_stall,
	output dp_cmd_t         cmd,
	output logic            cfg_ready
);
	typedef enum logic [1:0] {
		GROUND,
		ESCAPE,
		CSI,
		SGR
	} state_t;

	state_t state_q;
	logic   prefix_q;
	logic   take;
	logic   is_final;
	logic   is_prefix;

	assign in_stall = (state_q == SGR) || stat.out_busy;
	assign take = in_valid && !in_stall;
	assign cfg_ready = (state_q == GROUND) && !stat.out_busy;
	assign is_final = (byte_value >= 8'h40) && (byte_value <= 8'h7E);
	assign is_prefix = (byte_value == 8'h3F) || (byte_value == 8'h3E) ||
		(byte_value == 8'h21);

	always_comb begin
		cmd = '0;
		cmd.op = DP_NONE;
		if (state_q == SGR) begin
			cmd.sgr_step = 1'b1;
		end else if (take) begin
			unique case (state_q)
				GROUND: begin
					if (byte_value != 8'h1B) begin
						cmd.emit = 1'b1;
						cmd.kind = (byte_value < 8'h20 || byte_value == 8'h7F) ?
							EV_CONTROL : EV_PRINT;
					end
				end
				ESCAPE: begin
					if (byte_value == 8'h5B) cmd.op = DP_START;
					else if (byte_value == 8'h63) begin
						cmd.load_default = 1'b1;
						cmd.emit = 1'b1;
						cmd.kind = EV_RESET;
					end else if (byte_value == 8'h37) begin
						cmd.emit = 1'b1;
						cmd.kind = EV_SAVE;
					end else if (byte_value == 8'h38) begin
						cmd.emit = 1'b1;
						cmd.kind = EV_RESTORE;
					end
				end
				CSI: begin
					if (is_final) begin
						cmd.op = DP_CLOSE;
						if (byte_value == 8'h6D) cmd.sgr_start = 1'b1;
						else begin
							cmd.emit = 1'b1;
							cmd.kind = EV_CSI;
						end
					end else begin
						cmd.op = DP_BYTE;
						cmd.prefix_ok = prefix_q && is_prefix;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= GROUND;
			prefix_q <= 1'b1;
		end else if (state_q == SGR) begin
			if (stat.sgr_done) state_q <= GROUND;
		end else if (take) begin
			unique case (state_q)
				GROUND: if (byte_value == 8'h1B) state_q <= ESCAPE;
				ESCAPE: begin
					state_q <= (byte_value == 8'h5B) ? CSI : GROUND;
					prefix_q <= 1'b1;
				end
				CSI: begin
					if (is_final) state_q <= (byte_value == 8'h6D) ? SGR : GROUND;
					else if (stat.overlong) begin
						state_q <= GROUND;
					end else if (!(prefix_q && is_prefix)) prefix_q <= 1'b0;
				end
				default: state_q <= GROUND;
			endcase
		end
	end

	`include "ansi_escape_parser_with_sgr_top_macros.svh"
	`AEP_ASSERT_IMPL(a_no_take_in_sgr, clk, arst_n, state_q == SGR, in_stall)
	`AEP_ASSERT_NEXT(a_sgr_enter, clk, arst_n, cmd.sgr_start, state_q == SGR)
	`AEP_ASSERT_IMPL(a_cfg_idle, clk, arst_n, cfg_ready, state_q == GROUND)
endmodule
`default_nettype wire

@@ hw/rtl/aep_datapath.sv @@
`default_nettype none
module aep_datapath
	import aep_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  byte_value,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [19:0] cfg_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       event_kind,
	output logic [7:0]       char_code,
	output logic [19:0]      style_word,
	output logic [15:0]      first_param,
	output logic [15:0]      second_param,
	output logic [4:0]       param_count
);
	logic [15:0]      store_q [MaxParams];
	logic [SlotW-1:0] slot_q;
	logic [15:0]      acc_q;
	logic             inval_q;
	logic [LenW-1:0]  len_q;
	logic [19:0]      dflt_q;
	logic [19:0]      style_q;
	logic [SlotW-1:0] idx_q;
	logic [SlotW-1:0] n_q;
	logic [15:0]      p0;
	logic [15:0]      p1;
	logic [15:0]      p2;
	logic [15:0]      p3;
	logic [15:0]      p4;
	logic [19:0]      nstyle;
	logic [SlotW-1:0] adv;
	logic [8:0]       col;
	logic [15:0]      closed;
	logic [SlotW-1:0] nslot;
	logic [19:0]      acc10;
	logic             digit;

	function automatic logic [15:0] rd(input logic [SlotW-1:0] i);
		logic [SlotW:0] j;
		begin
			j = {1'b0, i};
			rd = (j < (SlotW+1)'(MaxParams)) ? store_q[i[IdxW-1:0]] : 16'd0;
		end
	endfunction

	assign p0 = rd(idx_q);
	assign p1 = rd(idx_q + SlotW'(1));
	assign p2 = rd(idx_q + SlotW'(2));
	assign p3 = rd(idx_q + SlotW'(3));
	assign p4 = rd(idx_q + SlotW'(4));
	assign col = 9'd16 + 9'd36 * {6'd0, cube_level(p2)} + 9'd6 * {6'd0, cube_level(p3)}
		+ {6'd0, cube_level(p4)};

	always_comb begin
		nstyle = style_q;
		adv = SlotW'(1);
		if (p0 == 16'd0) nstyle = dflt_q;
		else if (p0 == 16'd1) nstyle = style_q | BoldBit;
		else if (p0 == 16'd22) nstyle = style_q & ~BoldBit;
		else if (p0 == 16'd7) nstyle = style_q | InvBit;
		else if (p0 == 16'd27) nstyle = style_q & ~InvBit;
		else if (p0 >= 16'd30 && p0 <= 16'd37) nstyle[8:0] = 9'(p0 - 16'd30);
		else if (p0 == 16'd39) nstyle[8:0] = DefColor;
		else if (p0 >= 16'd40 && p0 <= 16'd47) nstyle[17:9] = 9'(p0 - 16'd40);
		else if (p0 == 16'd49) nstyle[17:9] = DefColor;
		else if (p0 >= 16'd90 && p0 <= 16'd97) nstyle[8:0] = 9'(p0 - 16'd82);
		else if (p0 >= 16'd100 && p0 <= 16'd107) nstyle[17:9] = 9'(p0 - 16'd92);
		else if ((p0 == 16'd38 || p0 == 16'd48) &&
			({1'b0, idx_q} + (SlotW+1)'(2) < {1'b0, n_q}) && p1 == 16'd5) begin
			if (p0 == 16'd48) nstyle[17:9] = (p2 > 16'd255) ? 9'd255 : 9'(p2);
			else nstyle[8:0] = (p2 > 16'd255) ? 9'd255 : 9'(p2);
			adv = SlotW'(3);
		end else if ((p0 == 16'd38 || p0 == 16'd48) &&
			({1'b0, idx_q} + (SlotW+1)'(4) < {1'b0, n_q}) && p1 == 16'd2) begin
			if (p0 == 16'd48) nstyle[17:9] = col;
			else nstyle[8:0] = col;
			adv = SlotW'(5);
		end
	end

	assign closed = inval_q ? 16'd0 : acc_q;
	assign nslot = ({1'b0, slot_q} < (SlotW+1)'(MaxParams)) ? slot_q + SlotW'(1) : slot_q;
	assign digit = byte_value >= 8'h30 && byte_value <= 8'h39;
	assign acc10 = {4'd0, acc_q} * 20'd10 + {16'd0, byte_value[3:0]};
	assign stat.overlong = ({1'b0, len_q} + (LenW+1)'(1)) > (LenW+1)'(MaxSeqLen);
	assign stat.sgr_done = {1'b0, idx_q} + {1'b0, adv} >= {1'b0, n_q};
	assign stat.out_busy = out_valid && out_stall;

	always_ff @(posedge clk) begin
		if (cmd.op == DP_CLOSE && {1'b0, slot_q} < (SlotW+1)'(MaxParams))
			store_q[slot_q[IdxW-1:0]] <= closed;
		else if (cmd.op == DP_BYTE && !stat.overlong && !cmd.prefix_ok &&
			byte_value == 8'h3B && {1'b0, slot_q} < (SlotW+1)'(MaxParams))
			store_q[slot_q[IdxW-1:0]] <= closed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			acc_q <= '0;
			inval_q <= 1'b0;
			len_q <= '0;
			dflt_q <= 20'h20100;
			style_q <= 20'h20100;
			idx_q <= '0;
			n_q <= '0;
			out_valid <= 1'b0;
			event_kind <= EV_PRINT;
			char_code <= '0;
			style_word <= '0;
			first_param <= '0;
			second_param <= '0;
			param_count <= 5'd1;
		end else begin
			if (cfg_valid && cfg_ready) dflt_q <= cfg_data;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cmd.load_default) style_q <= dflt_q;
			unique case (cmd.op)
				DP_START: begin
					slot_q <= '0;
					acc_q <= '0;
					inval_q <= 1'b0;
					len_q <= '0;
				end
				DP_CLOSE: begin
					slot_q <= nslot;
					acc_q <= '0;
					inval_q <= 1'b0;
					n_q <= nslot;
					idx_q <= '0;
				end
				DP_BYTE: begin
					len_q <= len_q + LenW'(1);
					if (stat.overlong) begin
						slot_q <= '0;
						acc_q <= '0;
						inval_q <= 1'b0;
						len_q <= '0;
					end else if (!cmd.prefix_ok) begin
						if (byte_value == 8'h3B) begin
							slot_q <= nslot;
							acc_q <= '0;
							inval_q <= 1'b0;
						end else if (digit) acc_q <= (acc10 > 20'd65535) ? 16'hFFFF : acc10[15:0];
						else inval_q <= 1'b1;
					end
				end
				default: ;
			endcase
			if (cmd.sgr_step) begin
				style_q <= nstyle;
				idx_q <= idx_q + adv;
			end
			if (cmd.emit) begin
				out_valid <= 1'b1;
				event_kind <= cmd.kind;
				char_code <= byte_value;
				style_word <= cmd.load_default ? dflt_q : style_q;
				param_count <= 5'd1;
				first_param <= '0;
				second_param <= '0;
				if (cmd.kind == EV_CSI) begin
					param_count <= 5'(nslot);
					first_param <= (slot_q == '0) ? closed : store_q[0];
					second_param <= (slot_q == SlotW'(1)) ? closed :
						((slot_q == '0) ? 16'd0 : store_q[1]);
				end
			end
		end
	end

	`include "ansi_escape_parser_with_sgr_top_macros.svh"
	`AEP_ASSERT_IMPL(a_emit_free, clk, arst_n, cmd.emit, !stat.out_busy)
	`AEP_ASSERT_IMPL(a_slot_range, clk, arst_n, 1'b1, {1'b0, slot_q} <= (SlotW+1)'(MaxParams))
	`AEP_ASSERT_NEXT(a_emit_valid, clk, arst_n, cmd.emit, out_valid)
endmodule
`default_nettype wire

@@ hw/rtl/ansi_escape_parser_with_sgr_top.sv @@
`default_nettype none
// Parses a terminal byte stream and emits one event per printable byte, control byte, CSI command
// or ESC c, ESC 7, ESC 8; SGR sequences update the tracked style and emit nothing. After an SGR
// final the block walks the stored parameters, up to 16 of them, while input is stalled. A
// waiting unread result stalls input too.
module ansi_escape_parser_with_sgr_top
	import aep_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  byte_value,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [19:0] default_style,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       event_kind,
	output logic [7:0]       char_code,
	output logic [19:0]      style_word,
	output logic [15:0]      first_param,
	output logic [15:0]      second_param,
	output logic [4:0]       param_count
);
	dp_cmd_t  cmd;
	dp_stat_t stat;

	aep_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .byte_value, .stat, .in_stall, .cmd, .cfg_ready
	);

	aep_datapath u_dp (
		.clk, .arst_n, .byte_value, .cmd, .stat, .cfg_valid, .cfg_ready,
		.cfg_data(default_style), .out_valid, .out_stall, .event_kind, .char_code,
		.style_word, .first_param, .second_param, .param_count
	);
endmodule
`default_nettype wire
